// ===== rtl/aft_pkg.sv =====
// ----------------------------------------------------------------------------
// aft_pkg
// Shared widths, register indexes, op codes and constants of the aero load
// evaluator.
// ----------------------------------------------------------------------------
package aft_pkg;

    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int IDX_W     = 4;
    localparam int IN_DATA_W = 168;
    localparam int OUT_DATA_W = 128;

    localparam int RHO_W  = 21;
    localparam int AREA_W = 23;
    localparam int CD_W   = 21;
    localparam int CL_W   = 22;
    localparam int OFS_W  = 22;
    localparam int PTS_W  = 5;
    localparam int CFG_W  = 23;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_AIR_DENSITY   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONTAL_AREA  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAG_COEFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIFT_COEFF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_POINTS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PITCH_POINTS  = 3'd6;

    localparam logic [OP_W-1:0] OP_EVAL   = 2'd0;
    localparam logic [OP_W-1:0] OP_SPEED  = 2'd1;
    localparam logic [OP_W-1:0] OP_PITCH  = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // pi in Q32.32
    localparam logic [63:0] PI_Q32 = 64'd13493037705;

endpackage

// ===== rtl/aft_mul32.sv =====
// ----------------------------------------------------------------------------
// aft_mul32
// Shared 32x32 unsigned multiplier with registered product.
// ----------------------------------------------------------------------------
module aft_mul32 (
    input  logic        aclk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

// ===== rtl/aft_div.sv =====
// ----------------------------------------------------------------------------
// aft_div
// Restoring divider, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor; 32 quotient bits are produced.
// ----------------------------------------------------------------------------
module aft_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[63:32];
            quo_reg <= dividend[31:0];
        end else if (busy_reg) begin
            rem_reg <= ge ? 32'(trial - {1'b0, divisor}) : trial[31:0];
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/aft_tbl_mem.sv =====
// ----------------------------------------------------------------------------
// aft_tbl_mem
// Breakpoint/value table with registered read. Entries never written read
// as their reset value through per-entry valid bits.
// ----------------------------------------------------------------------------
module aft_tbl_mem #(
    parameter int          DEPTH    = 16,
    parameter int          AW       = 4,
    parameter logic [31:0] BRK0_RST = 32'd0,
    parameter logic [31:0] BRK1_RST = 32'd0
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_break,
    input  logic [31:0]   wr_value,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_break,
    output logic [31:0]   rd_value
);

    logic [63:0]      mem_reg [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [63:0]      rd_reg;
    logic [63:0]      rst_word;

    always_comb begin
        if (rd_addr == AW'(0)) begin
            rst_word = {32'd0, BRK0_RST};
        end else if (rd_addr == AW'(1)) begin
            rst_word = {32'd0, BRK1_RST};
        end else begin
            rst_word = 64'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= {wr_value, wr_break};
        end
        rd_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : rst_word;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign rd_break = rd_reg[31:0];
    assign rd_value = rd_reg[63:32];

endmodule

// ===== rtl/aero_force_torque_eval_core.sv =====
// ----------------------------------------------------------------------------
// aero_force_torque_eval_core
// Aerodynamic drag, lift and pitch torque from speed and pitch, with two
// interpolated tables loaded through op items.
// ----------------------------------------------------------------------------
// After an evaluate transfer each of the two table lookups ends early when
// the input is at or below the first breakpoint (or the table has one point)
// or at or above the last one; otherwise it takes one memory read per
// breakpoint scanned, a pass of the shared 32x32 multiplier, a divide and a
// rounding step. The nine products after that each take a pass of the same
// multiplier, and then the result moves into the output register, later
// while an earlier result still waits there. Table write items and unused
// ops are taken in the idle state. The input is not ready while an item is
// in work; a finished result waits in the output register while the next
// item is taken.
module aero_force_torque_eval_core #(
    parameter int TABLE_POINTS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // speed_long, speed_lat, pitch_angle, entry_index, entry_break,
    // entry_value, zero pad
    input  logic [aft_pkg::IN_DATA_W-1:0]     s_tdata,
    // op
    input  logic [aft_pkg::OP_W-1:0]          s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // force_x, force_y, force_z, torque_pitch
    output logic [aft_pkg::OUT_DATA_W-1:0]    m_tdata,
    // saturated
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [aft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [aft_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(TABLE_POINTS);
    localparam int NW = $clog2(TABLE_POINTS + 1);

    localparam logic [63:0] RHO_RST64  = ((64'd1225 << FRAC_BITS) + 64'd500) / 64'd1000;
    localparam logic [63:0] ONE_RST64  = 64'd1 << FRAC_BITS;
    localparam logic [63:0] LIFT_RST64 = 64'd0 - ((64'd3 << FRAC_BITS) >> 1);
    localparam logic [63:0] SPD1_RST64 = 64'd100 << FRAC_BITS;
    localparam logic [63:0] PIT1_RST64 =
        (aft_pkg::PI_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] PIT0_RST64 = 64'd0 - PIT1_RST64;

    localparam logic [127:0] HALF_F  = 128'd1 << (FRAC_BITS - 1);
    localparam logic [127:0] HALF_F1 = 128'd1 << FRAC_BITS;
    localparam logic [127:0] CAP62   = 128'd1 << 62;

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_RD0   = 13'b0000000000010,
        S_CHK0  = 13'b0000000000100,
        S_CHKL  = 13'b0000000001000,
        S_SCAN  = 13'b0000000010000,
        S_IMUL  = 13'b0000000100000,
        S_DST   = 13'b0000001000000,
        S_DWT   = 13'b0000010000000,
        S_IRES  = 13'b0000100000000,
        S_CLOAD = 13'b0001000000000,
        S_CMUL  = 13'b0010000000000,
        S_CFIN  = 13'b0100000000000,
        S_OUT   = 13'b1000000000000
    } state_t;

    typedef enum logic [8:0] {
        C_K   = 9'b000000001,
        C_KD  = 9'b000000010,
        C_AX2 = 9'b000000100,
        C_FX  = 9'b000001000,
        C_AY2 = 9'b000010000,
        C_FY  = 9'b000100000,
        C_KL  = 9'b001000000,
        C_FZ  = 9'b010000000,
        C_TQ  = 9'b100000000
    } calc_t;

    typedef struct packed {
        logic        clip;
        logic [31:0] data;
        logic [31:0] mag;
    } sat_t;

    function automatic sat_t sat32(input logic neg, input logic [62:0] mag);
        sat_t        s;
        logic [62:0] m;
        m      = mag;
        s.clip = 1'b0;
        if (!neg) begin
            if (mag > 63'h7FFF_FFFF) begin
                m      = 63'h7FFF_FFFF;
                s.clip = 1'b1;
            end
        end else begin
            if (mag > 63'h8000_0000) begin
                m      = 63'h8000_0000;
                s.clip = 1'b1;
            end
        end
        s.mag  = m[31:0];
        s.data = neg ? 32'd0 - m[31:0] : m[31:0];
        return s;
    endfunction

    state_t state_reg, state_next;
    calc_t  step_reg;

    logic [aft_pkg::RHO_W-1:0]  rho_reg;
    logic [aft_pkg::AREA_W-1:0] area_reg;
    logic [aft_pkg::CD_W-1:0]   cd_reg;
    logic [aft_pkg::CL_W-1:0]   cl_reg;
    logic [aft_pkg::OFS_W-1:0]  ofs_reg;
    logic [aft_pkg::PTS_W-1:0]  spts_reg;
    logic [aft_pkg::PTS_W-1:0]  ppts_reg;

    logic signed [31:0] vx_reg, vy_reg, th_reg;
    logic               tsel_reg;
    logic [AW-1:0]      j_reg;
    logic signed [31:0] pb_reg, pv_reg;
    logic [31:0]        den_reg;
    logic               dfneg_reg;
    logic [63:0]        opa_reg, opb_reg;
    logic               shsel_reg;
    logic [2:0]         mcnt_reg;
    logic [127:0]       acc_reg;
    logic signed [33:0] dcl_reg, shf_reg;
    logic [62:0]        k_reg, kd_reg, ax2_reg, ay2_reg, kl_reg;
    logic [31:0]        fzm_reg;
    logic               fzneg_reg;
    logic [31:0]        wfx_reg, wfy_reg, wfz_reg, wtq_reg;
    logic               wflag_reg;
    logic [aft_pkg::OUT_DATA_W-1:0] m_data_reg;
    logic               m_user_reg, m_valid_reg;

    logic               s_acc;
    logic [aft_pkg::OP_W-1:0] in_op;
    logic [3:0]         in_idx;
    logic               entry_ok;
    logic [AW-1:0]      wr_addr;
    logic               wr_spd, wr_pit;
    logic [AW-1:0]      rd_addr;
    logic [31:0]        spd_brk, spd_val, pit_brk, pit_val;
    logic signed [31:0] tb, tv, x;
    logic [aft_pkg::PTS_W-1:0] n_raw;
    logic [NW-1:0]      n, n_m1;
    logic               n_lt2, adv;
    logic signed [32:0] dx33, den33, df33;
    logic [31:0]        df_abs;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        prod;
    logic               div_done;
    logic [31:0]        div_q, div_r;
    logic               rnd_inc;
    logic [32:0]        q_rnd;
    logic signed [33:0] ires;
    logic signed [35:0] c36, arm36;
    logic [35:0]        c_abs, arm_abs;
    logic [127:0]       rnd_sum, shifted;
    logic [62:0]        ms_res;
    logic [31:0]        vx_abs, vy_abs;
    sat_t               sat_r;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_op    = s_tuser;
    assign in_idx   = s_tdata[99:96];
    assign entry_ok = 32'(in_idx) < TABLE_POINTS;
    assign wr_addr  = AW'(in_idx);
    assign wr_spd   = s_acc && (in_op == aft_pkg::OP_SPEED) && entry_ok;
    assign wr_pit   = s_acc && (in_op == aft_pkg::OP_PITCH) && entry_ok;

    aft_tbl_mem #(
        .DEPTH(TABLE_POINTS), .AW(AW),
        .BRK0_RST(32'd0), .BRK1_RST(SPD1_RST64[31:0])
    ) u_spd (
        .aclk(aclk), .aresetn(aresetn), .wr_en(wr_spd), .wr_addr(wr_addr),
        .wr_break(s_tdata[131:100]), .wr_value(s_tdata[163:132]),
        .rd_addr(rd_addr), .rd_break(spd_brk), .rd_value(spd_val)
    );

    aft_tbl_mem #(
        .DEPTH(TABLE_POINTS), .AW(AW),
        .BRK0_RST(PIT0_RST64[31:0]), .BRK1_RST(PIT1_RST64[31:0])
    ) u_pit (
        .aclk(aclk), .aresetn(aresetn), .wr_en(wr_pit), .wr_addr(wr_addr),
        .wr_break(s_tdata[131:100]), .wr_value(s_tdata[163:132]),
        .rd_addr(rd_addr), .rd_break(pit_brk), .rd_value(pit_val)
    );

    aft_mul32 u_mul (.aclk(aclk), .a(mul_a), .b(mul_b), .p(prod));

    aft_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(state_reg == S_DST),
        .dividend(acc_reg[63:0]), .divisor(den_reg), .done(div_done),
        .quotient(div_q), .remainder(div_r)
    );

    // table lookup datapath
    always_comb begin
        tb    = tsel_reg ? $signed(pit_brk) : $signed(spd_brk);
        tv    = tsel_reg ? $signed(pit_val) : $signed(spd_val);
        x     = tsel_reg ? th_reg : vx_reg;
        n_raw = tsel_reg ? ppts_reg : spts_reg;
        if (n_raw == '0) begin
            n = NW'(1);
        end else if (32'(n_raw) > TABLE_POINTS) begin
            n = NW'(TABLE_POINTS);
        end else begin
            n = NW'(n_raw);
        end
        n_m1   = n - NW'(1);
        n_lt2  = (n == NW'(1));
        adv    = (NW'(j_reg) < n_m1) && (x >= tb);
        dx33   = 33'(x) - 33'(pb_reg);
        den33  = 33'(tb) - 33'(pb_reg);
        df33   = 33'(tv) - 33'(pv_reg);
        df_abs = df33[32] ? 32'(33'd0 - df33) : df33[31:0];
    end

    always_comb begin
        case (state_reg)
            S_CHK0:  rd_addr = AW'(n_m1);
            S_CHKL:  rd_addr = AW'(1);
            S_SCAN:  rd_addr = j_reg + AW'(1);
            default: rd_addr = '0;
        endcase
    end

    always_comb begin
        rnd_inc = ({1'b0, div_r} + {1'b0, div_r}) >= {1'b0, den_reg};
        q_rnd   = {1'b0, div_q} + 33'(rnd_inc);
        ires    = dfneg_reg ? 34'(pv_reg) - 34'(q_rnd) : 34'(pv_reg) + 34'(q_rnd);
    end

    // product datapath
    always_comb begin
        case (mcnt_reg)
            3'd0:    begin mul_a = opa_reg[31:0];  mul_b = opb_reg[31:0];  end
            3'd1:    begin mul_a = opa_reg[31:0];  mul_b = opb_reg[63:32]; end
            3'd2:    begin mul_a = opa_reg[63:32]; mul_b = opb_reg[31:0];  end
            default: begin mul_a = opa_reg[63:32]; mul_b = opb_reg[63:32]; end
        endcase
        rnd_sum = acc_reg + (shsel_reg ? HALF_F1 : HALF_F);
        shifted = shsel_reg ? (rnd_sum >> (FRAC_BITS + 1)) : (rnd_sum >> FRAC_BITS);
        ms_res  = (shifted > CAP62) ? CAP62[62:0] : shifted[62:0];
    end

    // drag opposes the motion; zero speed counts as forward
    always_comb begin
        c36     = 36'($signed(cl_reg)) + 36'(dcl_reg);
        arm36   = 36'($signed(ofs_reg)) + 36'(shf_reg);
        c_abs   = c36[35] ? 36'd0 - c36 : c36;
        arm_abs = arm36[35] ? 36'd0 - arm36 : arm36;
        vx_abs  = vx_reg[31] ? 32'd0 - vx_reg : vx_reg;
        vy_abs  = vy_reg[31] ? 32'd0 - vy_reg : vy_reg;
        case (step_reg)
            C_FX:    sat_r = sat32(!vx_reg[31], ms_res);
            C_FY:    sat_r = sat32(!vy_reg[31], ms_res);
            C_FZ:    sat_r = sat32(c36[35], ms_res);
            default: sat_r = sat32(fzneg_reg == arm36[35], ms_res);
        endcase
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc && (in_op == aft_pkg::OP_EVAL)) state_next = S_RD0;
            end
            S_RD0: state_next = S_CHK0;
            S_CHK0: begin
                if (n_lt2 || (x <= tb)) begin
                    state_next = tsel_reg ? S_CLOAD : S_RD0;
                end else begin
                    state_next = S_CHKL;
                end
            end
            S_CHKL: begin
                if (x >= tb) begin
                    state_next = tsel_reg ? S_CLOAD : S_RD0;
                end else begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!adv) state_next = S_IMUL;
            end
            S_IMUL: begin
                if (mcnt_reg == 3'd4) state_next = S_DST;
            end
            S_DST: state_next = S_DWT;
            S_DWT: begin
                if (div_done) state_next = S_IRES;
            end
            S_IRES: state_next = tsel_reg ? S_CLOAD : S_RD0;
            S_CLOAD: state_next = S_CMUL;
            S_CMUL: begin
                if (mcnt_reg == 3'd4) state_next = S_CFIN;
            end
            S_CFIN: state_next = (step_reg == C_TQ) ? S_OUT : S_CLOAD;
            S_OUT: begin
                if (!m_valid_reg || m_tready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rho_reg     <= RHO_RST64[aft_pkg::RHO_W-1:0];
            area_reg    <= ONE_RST64[aft_pkg::AREA_W-1:0];
            cd_reg      <= ONE_RST64[aft_pkg::CD_W-1:0];
            cl_reg      <= LIFT_RST64[aft_pkg::CL_W-1:0];
            ofs_reg     <= '0;
            spts_reg    <= aft_pkg::PTS_W'(2);
            ppts_reg    <= aft_pkg::PTS_W'(2);
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    aft_pkg::CFG_AIR_DENSITY:   rho_reg  <= cfg_data[aft_pkg::RHO_W-1:0];
                    aft_pkg::CFG_FRONTAL_AREA:  area_reg <= cfg_data[aft_pkg::AREA_W-1:0];
                    aft_pkg::CFG_DRAG_COEFF:    cd_reg   <= cfg_data[aft_pkg::CD_W-1:0];
                    aft_pkg::CFG_LIFT_COEFF:    cl_reg   <= cfg_data[aft_pkg::CL_W-1:0];
                    aft_pkg::CFG_CENTER_OFFSET: ofs_reg  <= cfg_data[aft_pkg::OFS_W-1:0];
                    aft_pkg::CFG_SPEED_POINTS:  spts_reg <= cfg_data[aft_pkg::PTS_W-1:0];
                    aft_pkg::CFG_PITCH_POINTS:  ppts_reg <= cfg_data[aft_pkg::PTS_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid_reg && m_tready) m_valid_reg <= 1'b0;
            if ((state_reg == S_OUT) && (!m_valid_reg || m_tready)) m_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                vx_reg   <= $signed(s_tdata[31:0]);
                vy_reg   <= $signed(s_tdata[63:32]);
                th_reg   <= $signed(s_tdata[95:64]);
                tsel_reg <= 1'b0;
            end
            S_CHK0: begin
                pb_reg <= tb;
                pv_reg <= tv;
                if (n_lt2 || (x <= tb)) begin
                    if (tsel_reg) shf_reg <= 34'(tv);
                    else          dcl_reg <= 34'(tv);
                    tsel_reg <= 1'b1;
                    step_reg <= C_K;
                end
            end
            S_CHKL: begin
                j_reg <= AW'(1);
                if (x >= tb) begin
                    if (tsel_reg) shf_reg <= 34'(tv);
                    else          dcl_reg <= 34'(tv);
                    tsel_reg <= 1'b1;
                    step_reg <= C_K;
                end
            end
            S_SCAN: begin
                if (adv) begin
                    j_reg  <= j_reg + AW'(1);
                    pb_reg <= tb;
                    pv_reg <= tv;
                end else begin
                    den_reg   <= den33[31:0];
                    dfneg_reg <= df33[32];
                    opa_reg   <= 64'(df_abs);
                    opb_reg   <= 64'(dx33[31:0]);
                    mcnt_reg  <= '0;
                    acc_reg   <= '0;
                end
            end
            S_IRES: begin
                if (tsel_reg) shf_reg <= ires;
                else          dcl_reg <= ires;
                tsel_reg <= 1'b1;
                step_reg <= C_K;
            end
            S_CLOAD: begin
                mcnt_reg  <= '0;
                acc_reg   <= '0;
                shsel_reg <= (step_reg == C_K);
                case (step_reg)
                    C_K:     begin opa_reg <= 64'(rho_reg); opb_reg <= 64'(area_reg); end
                    C_KD:    begin opa_reg <= 64'(k_reg);   opb_reg <= 64'(cd_reg);   end
                    C_AX2:   begin opa_reg <= 64'(vx_abs);  opb_reg <= 64'(vx_abs);   end
                    C_FX:    begin opa_reg <= 64'(kd_reg);  opb_reg <= 64'(ax2_reg);  end
                    C_AY2:   begin opa_reg <= 64'(vy_abs);  opb_reg <= 64'(vy_abs);   end
                    C_FY:    begin opa_reg <= 64'(kd_reg);  opb_reg <= 64'(ay2_reg);  end
                    C_KL:    begin opa_reg <= 64'(k_reg);   opb_reg <= 64'(c_abs);    end
                    C_FZ:    begin opa_reg <= 64'(kl_reg);  opb_reg <= 64'(ax2_reg);  end
                    default: begin opa_reg <= 64'(fzm_reg); opb_reg <= 64'(arm_abs);  end
                endcase
            end
            S_CFIN: begin
                case (step_reg)
                    C_K:   begin k_reg   <= ms_res; step_reg <= C_KD;  end
                    C_KD:  begin kd_reg  <= ms_res; step_reg <= C_AX2; end
                    C_AX2: begin ax2_reg <= ms_res; step_reg <= C_FX;  end
                    C_FX: begin
                        wfx_reg   <= sat_r.data;
                        wflag_reg <= sat_r.clip;
                        step_reg  <= C_AY2;
                    end
                    C_AY2: begin ay2_reg <= ms_res; step_reg <= C_FY;  end
                    C_FY: begin
                        wfy_reg   <= sat_r.data;
                        wflag_reg <= wflag_reg | sat_r.clip;
                        step_reg  <= C_KL;
                    end
                    C_KL:  begin kl_reg  <= ms_res; step_reg <= C_FZ;  end
                    C_FZ: begin
                        wfz_reg   <= sat_r.data;
                        fzm_reg   <= sat_r.mag;
                        fzneg_reg <= c36[35];
                        wflag_reg <= wflag_reg | sat_r.clip;
                        step_reg  <= C_TQ;
                    end
                    default: begin
                        wtq_reg   <= sat_r.data;
                        wflag_reg <= wflag_reg | sat_r.clip;
                    end
                endcase
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_reg <= {wtq_reg, wfz_reg, wfy_reg, wfx_reg};
                    m_user_reg <= wflag_reg;
                end
            end
            default: ;
        endcase

        // partial product accumulate
        if ((state_reg == S_IMUL) || (state_reg == S_CMUL)) begin
            mcnt_reg <= mcnt_reg + 3'd1;
            case (mcnt_reg)
                3'd1:      acc_reg <= acc_reg + 128'(prod);
                3'd2,
                3'd3:      acc_reg <= acc_reg + (128'(prod) << 32);
                3'd4:      acc_reg <= acc_reg + (128'(prod) << 64);
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
